@@ rtl/http_quality_value_parser_defines.svh @@
// ---------------------------------------------------------------------------
// HTTP quality value parser - assertion macros
// Shared concurrent assertion wrappers for the parser RTL.
// ---------------------------------------------------------------------------
`ifndef HTTP_QUALITY_VALUE_PARSER_DEFINES_SVH
`define HTTP_QUALITY_VALUE_PARSER_DEFINES_SVH

// Checked only outside reset.
`define HQVP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hqvp: assertion failed");

// Checked on every edge, reset included.
`define HQVP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("hqvp: assertion failed");

`endif

@@ rtl/hqvp_pkg.sv @@
// ---------------------------------------------------------------------------
// HTTP quality value parser - package
// Beat types and shared constants.
// ---------------------------------------------------------------------------
package hqvp_pkg;

   localparam int MAX_LEN_DEFAULT = 4096;

   localparam int BYTE_W    = 8;
   localparam int QUAL_W    = 10;
   localparam int OFFSET_W  = 12;
   localparam int LENGTH_W  = 13;

   localparam logic [QUAL_W-1:0] QUAL_ONE = QUAL_W'(1000);

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic                has_quality;
      logic [QUAL_W-1:0]   quality_milli;
      logic [OFFSET_W-1:0] token_offset;
      logic [LENGTH_W-1:0] token_length;
   } rsp_type;

endpackage

@@ rtl/http_quality_value_parser.sv @@
// ---------------------------------------------------------------------------
// HTTP quality value parser
// Parses "token [; q=number]" one byte per beat and reports the token
// position and quality in thousandths on the last byte.
// Latency: the result of a last byte is on rsp_valid the cycle after it.
// Throughput: one byte per cycle unless a last byte stalls; the per-byte
// phase update and result decode sit between state and result registers.
// Reset: synchronous; parser returns to leading-blank phase, no result held.
// ---------------------------------------------------------------------------
`include "http_quality_value_parser_defines.svh"

module http_quality_value_parser #(
   parameter int MAX_LEN = hqvp_pkg::MAX_LEN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hqvp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hqvp_pkg::rsp_type rsp_data
);
   import hqvp_pkg::*;

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int EXT_W = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_Q_LO  = 8'h71;
   localparam logic [7:0] CH_Q_UP  = 8'h51;

   typedef enum logic [2:0] {
      PH_LEAD, PH_TOKEN, PH_AFTOK, PH_SEMI, PH_Q, PH_EQ, PH_NUM, PH_ERR
   } phase_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_tchar(input logic [7:0] c);
      logic alnum;
      alnum = is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h61) && (c <= 8'h7A));
      return alnum || (c == 8'h21) || (c == 8'h23) || (c == 8'h24) ||
             (c == 8'h25) || (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) ||
             (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) ||
             (c == 8'h5F) || (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
   endfunction

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   tok_start_ff, tok_start_in;
   logic [POS_W-1:0]   tok_end_ff, tok_end_in;
   logic               int_over_ff, int_over_in;
   logic               int_one_ff, int_one_in;
   logic [1:0]         frac_cnt_ff, frac_cnt_in;
   logic [QUAL_W-1:0]  frac_acc_ff, frac_acc_in;
   logic               frac_nz_ff, frac_nz_in;
   logic               nf_digit_ff, nf_digit_in;
   logic               nf_dot_ff, nf_dot_in;
   logic               nf_trail_ff, nf_trail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic [7:0]         c;
   logic               take_digit;
   logic [3:0]         dval;
   logic [EXT_W-1:0]   start_x, len_x;

   // A last byte needs the result register; other bytes never wait.
   assign req_stall = rsp_valid_ff && rsp_stall && req_data.last_byte;
   assign req_take  = req_valid && !req_stall;
   assign c         = req_data.byte_in;
   assign dval      = c[3:0];

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tok_start_in = tok_start_ff;
      tok_end_in   = tok_end_ff;
      int_over_in  = int_over_ff;
      int_one_in   = int_one_ff;
      frac_cnt_in  = frac_cnt_ff;
      frac_acc_in  = frac_acc_ff;
      frac_nz_in   = frac_nz_ff;
      nf_digit_in  = nf_digit_ff;
      nf_dot_in    = nf_dot_ff;
      nf_trail_in  = nf_trail_ff;
      take_digit   = 1'b0;
      rsp_data_in  = '0;
      start_x      = '0;
      len_x        = '0;

      if (pos_ff == POS_MAX) begin
         phase_in = PH_ERR;
      end else begin
         pos_in = pos_ff + 1'b1;
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_tchar(c)) begin
                  tok_start_in = pos_ff;
                  tok_end_in   = pos_ff + 1'b1;
                  phase_in     = PH_TOKEN;
               end else if (!is_blank(c)) begin
                  phase_in = PH_ERR;
               end
            end
            PH_TOKEN: begin
               if (is_tchar(c))         tok_end_in = pos_ff + 1'b1;
               else if (is_blank(c))    phase_in = PH_AFTOK;
               else if (c == CH_SEMI)   phase_in = PH_SEMI;
               else                     phase_in = PH_ERR;
            end
            PH_AFTOK: begin
               if (!is_blank(c)) phase_in = (c == CH_SEMI) ? PH_SEMI : PH_ERR;
            end
            PH_SEMI: begin
               if (!is_blank(c))
                  phase_in = ((c == CH_Q_LO) || (c == CH_Q_UP)) ? PH_Q : PH_ERR;
            end
            PH_Q: begin
               if (!is_blank(c)) phase_in = (c == CH_EQ) ? PH_EQ : PH_ERR;
            end
            PH_EQ: begin
               if (is_digit(c)) begin
                  phase_in   = PH_NUM;
                  take_digit = 1'b1;
               end else if (!is_blank(c)) begin
                  phase_in = PH_ERR;
               end
            end
            PH_NUM: begin
               if (is_blank(c))                     nf_trail_in = 1'b1;
               else if (nf_trail_ff)                phase_in = PH_ERR;
               else if (is_digit(c))                take_digit = 1'b1;
               else if (c == CH_DOT && !nf_dot_ff)  nf_dot_in = 1'b1;
               else                                 phase_in = PH_ERR;
            end
            PH_ERR: phase_in = PH_ERR;
            default: phase_in = PH_ERR;
         endcase
      end

      if (take_digit) begin
         nf_digit_in = 1'b1;
         if (nf_dot_ff) begin
            if (dval != 4'd0) frac_nz_in = 1'b1;
            if (frac_cnt_ff != 2'd3) begin
               frac_acc_in = QUAL_W'(frac_acc_ff * 4'd10) + QUAL_W'(dval);
               frac_cnt_in = frac_cnt_ff + 1'b1;
            end
         end else if (int_over_ff) begin
            int_over_in = 1'b1;
         end else if (int_one_ff) begin
            int_one_in  = 1'b0;
            int_over_in = 1'b1;
         end else if (dval == 4'd1) begin
            int_one_in = 1'b1;
         end else if (dval > 4'd1) begin
            int_over_in = 1'b1;
         end
      end

      // Result decode from the post-byte state.
      if ((phase_in == PH_TOKEN) || (phase_in == PH_AFTOK)) begin
         rsp_data_in.ok            = 1'b1;
         rsp_data_in.quality_milli = QUAL_ONE;
      end else if ((phase_in == PH_NUM) && !int_over_in && !(int_one_in && frac_nz_in)) begin
         rsp_data_in.ok          = 1'b1;
         rsp_data_in.has_quality = 1'b1;
         if (int_one_in) begin
            rsp_data_in.quality_milli = QUAL_ONE;
         end else begin
            unique case (frac_cnt_in)
               2'd1:    rsp_data_in.quality_milli = QUAL_W'(frac_acc_in * 7'd100);
               2'd2:    rsp_data_in.quality_milli = QUAL_W'(frac_acc_in * 4'd10);
               2'd3:    rsp_data_in.quality_milli = frac_acc_in;
               default: rsp_data_in.quality_milli = '0;
            endcase
         end
      end
      if (rsp_data_in.ok) begin
         start_x = EXT_W'(tok_start_in);
         len_x   = EXT_W'(POS_W'(tok_end_in - tok_start_in));
         rsp_data_in.token_offset = start_x[OFFSET_W-1:0];
         rsp_data_in.token_length = len_x[LENGTH_W-1:0];
      end

      // End of element: back to the leading-blank phase.
      if (req_data.last_byte) begin
         phase_in     = PH_LEAD;
         pos_in       = '0;
         tok_start_in = '0;
         tok_end_in   = '0;
         int_over_in  = 1'b0;
         int_one_in   = 1'b0;
         frac_cnt_in  = '0;
         frac_acc_in  = '0;
         frac_nz_in   = 1'b0;
         nf_digit_in  = 1'b0;
         nf_dot_in    = 1'b0;
         nf_trail_in  = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_take && req_data.last_byte) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         pos_ff       <= '0;
         tok_start_ff <= '0;
         tok_end_ff   <= '0;
         int_over_ff  <= 1'b0;
         int_one_ff   <= 1'b0;
         frac_cnt_ff  <= '0;
         frac_acc_ff  <= '0;
         frac_nz_ff   <= 1'b0;
         nf_digit_ff  <= 1'b0;
         nf_dot_ff    <= 1'b0;
         nf_trail_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            tok_start_ff <= tok_start_in;
            tok_end_ff   <= tok_end_in;
            int_over_ff  <= int_over_in;
            int_one_ff   <= int_one_in;
            frac_cnt_ff  <= frac_cnt_in;
            frac_acc_ff  <= frac_acc_in;
            frac_nz_ff   <= frac_nz_in;
            nf_digit_ff  <= nf_digit_in;
            nf_dot_ff    <= nf_dot_in;
            nf_trail_ff  <= nf_trail_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take && req_data.last_byte) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // nf_digit is tracked for the number phase; a number entry implies it.
   `HQVP_ASSERT(a_num_has_digit, clock, reset, (phase_ff == PH_NUM) |-> nf_digit_ff)
   `HQVP_ASSERT(a_last_gives_rsp, clock, reset,
      (req_valid && !req_stall && req_data.last_byte) |=> rsp_valid)
   `HQVP_ASSERT(a_bad_is_zero, clock, reset,
      (rsp_valid && !rsp_data.ok) |-> (!rsp_data.has_quality &&
      (rsp_data.quality_milli == '0) && (rsp_data.token_offset == '0) &&
      (rsp_data.token_length == '0)))
   `HQVP_ASSERT(a_qual_range, clock, reset,
      (rsp_valid && rsp_data.ok) |-> ((rsp_data.quality_milli <= QUAL_ONE) &&
      (rsp_data.has_quality || (rsp_data.quality_milli == QUAL_ONE)) &&
      (rsp_data.token_length != '0)))
   `HQVP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule
